// File: rtl/sipq_pkg.sv
// Shared types and codes for the sorted-insert priority queue.
// Depends on nothing; used by sipq_ram and sorted_insert_priority_queue.
package sipq_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REMOVED  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [15:0] item_tag;
        logic [15:0] priority_req;
    } request_t;

    typedef struct packed {
        logic [15:0] out_tag;
        logic [15:0] out_priority;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } response_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] pri;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_LAST,
        S_POP_HEAD,
        S_POP_SHIFT
    } state_t;

endpackage

// File: rtl/sipq_ram.sv
// Entry store: one write port and one read port with registered read data.
// Depends on sipq_pkg for the entry type.
module sipq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  sipq_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output sipq_pkg::entry_t rdata
);

    sipq_pkg::entry_t mem [DEPTH];
    sipq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sorted_insert_priority_queue.sv
// Sorted-insert priority queue top level: command sequencer and entry store.
// Depends on sipq_pkg and sipq_ram.
//
// A command is taken when start is high and busy is low; its single result
// appears on response with done high for one cycle and cannot be stalled.
// Entries live in one RAM sorted by priority number, head at address 0, and
// one comparator walks them one entry per cycle. A rejected command (remove
// when empty, insert when full) and an insert into an empty queue finish
// straight from idle. Any other insert compares entries from the tail,
// moving each with a larger priority number one place toward the tail, and
// then writes the new entry, whether it lands at the head or further back.
// A remove reads the head, then moves every remaining entry one place
// toward the head. No clearing pass is needed after reset.
module sorted_insert_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sipq_pkg::request_t  request,
    output logic                busy,
    output logic                done,
    output sipq_pkg::response_t response
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    sipq_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [15:0]         tag_reg, tag_next;
    logic [15:0]         pri_reg, pri_next;
    sipq_pkg::response_t res_reg, res_next;
    logic                done_reg, done_next;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    sipq_pkg::entry_t    wdata;
    sipq_pkg::entry_t    rd_entry;
    sipq_pkg::entry_t    new_entry;
    logic [CW-1:0]       count_inc;
    logic [CW-1:0]       count_dec;

    sipq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    assign new_entry.tag = tag_reg;
    assign new_entry.pri = pri_reg;
    assign count_inc     = count_reg + CW'(1);
    assign count_dec     = count_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sipq_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        tag_reg <= tag_next;
        pri_reg <= pri_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        tag_next   = tag_reg;
        pri_next   = pri_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = '0;
        wdata      = rd_entry;
        raddr      = '0;

        case (state_reg)
            sipq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    tag_next = request.item_tag;
                    pri_next = request.priority_req;
                    if (request.cmd == sipq_pkg::CMD_INSERT)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            res_next  = '{16'd0, 16'd0, sipq_pkg::STATUS_FULL, 5'(count_reg)};
                            done_next = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata.tag  = request.item_tag;
                            wdata.pri  = request.priority_req;
                            count_next = count_inc;
                            res_next   = '{16'd0, 16'd0, sipq_pkg::STATUS_INSERTED,
                                          5'(count_inc)};
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            raddr      = AW'(count_dec);
                            idx_next   = AW'(count_dec);
                            state_next = sipq_pkg::S_INS_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next  = '{16'd0, 16'd0, sipq_pkg::STATUS_EMPTY, 5'd0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            raddr      = '0;
                            state_next = sipq_pkg::S_POP_HEAD;
                        end
                    end
                end
            end

            sipq_pkg::S_INS_CMP:
            begin
                we    = 1'b1;
                waddr = idx_reg + AW'(1);
                if (rd_entry.pri > pri_reg)
                begin
                    wdata = rd_entry;
                    if (idx_reg == '0)
                    begin
                        state_next = sipq_pkg::S_INS_LAST;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                        raddr    = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    wdata      = new_entry;
                    count_next = count_inc;
                    res_next   = '{16'd0, 16'd0, sipq_pkg::STATUS_INSERTED, 5'(count_inc)};
                    done_next  = 1'b1;
                    state_next = sipq_pkg::S_IDLE;
                end
            end

            sipq_pkg::S_INS_LAST:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = new_entry;
                count_next = count_inc;
                res_next   = '{16'd0, 16'd0, sipq_pkg::STATUS_INSERTED, 5'(count_inc)};
                done_next  = 1'b1;
                state_next = sipq_pkg::S_IDLE;
            end

            sipq_pkg::S_POP_HEAD:
            begin
                res_next = '{rd_entry.tag, rd_entry.pri, sipq_pkg::STATUS_REMOVED,
                             5'(count_dec)};
                if (count_reg == CW'(1))
                begin
                    count_next = count_dec;
                    done_next  = 1'b1;
                    state_next = sipq_pkg::S_IDLE;
                end
                else
                begin
                    idx_next   = AW'(1);
                    raddr      = AW'(1);
                    state_next = sipq_pkg::S_POP_SHIFT;
                end
            end

            sipq_pkg::S_POP_SHIFT:
            begin
                we    = 1'b1;
                waddr = idx_reg - AW'(1);
                wdata = rd_entry;
                if (CW'(idx_reg) + CW'(1) == count_reg)
                begin
                    count_next = count_dec;
                    done_next  = 1'b1;
                    state_next = sipq_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    raddr    = idx_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = sipq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != sipq_pkg::S_IDLE);
    assign done     = done_reg;
    assign response = res_reg;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither started nor finished");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status == sipq_pkg::STATUS_INSERTED)
        |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance entry count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status == sipq_pkg::STATUS_FULL)
        |-> (count_reg == CW'(CAPACITY)))
        else $error("full reported below capacity");

endmodule
